FILE: src/smvm_pkg.sv
// ----------------------------------------------------------------------------
// smvm_pkg: shared types and constants
// Opcodes, configuration register indexes, sequencer states and field widths
// for the sparse matrix times vector block.
// ----------------------------------------------------------------------------
package smvm_pkg;

  // Fixed field widths.
  localparam int unsigned IdxW = 10;
  localparam int unsigned ValW = 32;
  localparam int unsigned LenW = 11;
  localparam int unsigned OpW  = 2;
  localparam int unsigned CfgW = 11;

  // Default store depth.
  localparam int unsigned VectorDepthDefault = 1024;

  // Reset value of the length register.
  localparam logic [LenW-1:0] LengthReset = LenW'(1024);

  // Request opcodes.
  typedef enum logic [OpW-1:0] {
    OP_LOAD  = 2'd0,
    OP_APPLY = 2'd1,
    OP_READ  = 2'd2
  } opcode_e;

  // Configuration register indexes.
  typedef enum logic {
    CFG_TRANSPOSE = 1'b0,
    CFG_LENGTH    = 1'b1
  } cfg_index_e;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_MUL,
    ST_ACC,
    ST_READ
  } state_e;

endpackage

FILE: src/smvm_mac.sv
// ----------------------------------------------------------------------------
// smvm_mac: multiply and saturating accumulate
// Registers the full Q32.32 product of an entry and a vector element, then
// truncates it to Q16.16 and adds it to the accumulator with saturation.
// ----------------------------------------------------------------------------
module smvm_mac
  import smvm_pkg::ValW;
(
  input  logic                   clk_i,
  input  logic                   mul_en_i,
  input  logic signed [ValW-1:0] entry_value_i,
  input  logic signed [ValW-1:0] vector_value_i,
  input  logic signed [ValW-1:0] accum_i,
  output logic signed [ValW-1:0] sum_o
);
  import smvm_pkg::*;

  localparam int unsigned ProdW = 2 * ValW;
  localparam logic signed [ProdW-1:0] SatMax = ProdW'(64'sd2147483647);
  localparam logic signed [ProdW-1:0] SatMin = -ProdW'(64'sd2147483648);

  logic signed [ProdW-1:0] prod_q;
  logic signed [ProdW-1:0] prod_d;
  logic signed [ProdW-1:0] sum_wide;

  // Full-precision product, registered before the add.
  assign prod_d = ProdW'(entry_value_i) * ProdW'(vector_value_i);

  always_ff @(posedge clk_i) begin
    if (mul_en_i) begin
      prod_q <= prod_d;
    end
  end

  // Truncate toward minus infinity, add and clamp to the 32-bit range.
  always_comb begin
    sum_wide = ProdW'(accum_i) + (prod_q >>> 16);
    if (sum_wide > SatMax) begin
      sum_o = ValW'(SatMax);
    end else if (sum_wide < SatMin) begin
      sum_o = ValW'(SatMin);
    end else begin
      sum_o = ValW'(sum_wide);
    end
  end

endmodule

FILE: src/sparse_matrix_vector_multiply_top.sv
// ----------------------------------------------------------------------------
// sparse_matrix_vector_multiply_top: sparse matrix times dense vector
// Coordinate-form entries accumulate value times a vector element into a
// result store; a read request returns and clears one result element.
//
// A request is taken when start is high and busy is low. A load, an unused
// opcode and an apply request dropped because one of its indices is at or
// beyond the length leave busy low. Any other apply request reads the vector
// and result stores in the accept cycle, registers the product in ST_MUL and
// writes the saturated sum back in ST_ACC. A read request presents its
// result on the cycle after acceptance for exactly one cycle, marked by
// result_valid_o; the receiver cannot stall it. The rate is set by the
// sequencer, which carries one request at a time through read, multiply and
// write-back and holds busy high until the write-back lands, so no two
// requests overlap and no forwarding is needed. After reset the result store
// is cleared one entry a cycle, over all VECTOR_DEPTH entries, with busy held
// high; configuration writes are taken during that pass.
// ----------------------------------------------------------------------------
module sparse_matrix_vector_multiply_top
  import smvm_pkg::IdxW;
  import smvm_pkg::ValW;
  import smvm_pkg::OpW;
  import smvm_pkg::CfgW;
  import smvm_pkg::VectorDepthDefault;
#(
  parameter int unsigned VECTOR_DEPTH = VectorDepthDefault
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // Request channel
  input  logic                   start,
  output logic                   busy,
  input  logic [OpW-1:0]         opcode_i,
  input  logic [IdxW-1:0]        element_index_i,
  input  logic signed [ValW-1:0] element_value_i,
  input  logic [IdxW-1:0]        entry_row_i,
  input  logic [IdxW-1:0]        entry_column_i,
  input  logic signed [ValW-1:0] entry_value_i,
  // Configuration port
  input  logic                   cfg_we_i,
  input  logic                   cfg_index_i,
  input  logic [CfgW-1:0]        cfg_wdata_i,
  // Result channel
  output logic                   result_valid_o,
  output logic [IdxW-1:0]        result_index_o,
  output logic signed [ValW-1:0] result_value_o,
  output logic                   index_error_o
);
  import smvm_pkg::*;

  localparam int unsigned AW = (VECTOR_DEPTH > 1) ? $clog2(VECTOR_DEPTH) : 1;
  localparam logic [AW-1:0] LastAddr = AW'(VECTOR_DEPTH - 1);

  // Configuration registers.
  logic            transpose_q;
  logic [LenW-1:0] length_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      transpose_q <= 1'b0;
      length_q    <= LengthReset;
    end else if (cfg_we_i) begin
      case (cfg_index_e'(cfg_index_i))
        CFG_TRANSPOSE: transpose_q <= cfg_wdata_i[0];
        CFG_LENGTH:    length_q    <= LenW'(cfg_wdata_i);
        default:       ;
      endcase
    end
  end

  // Range checks against the effective length min(length, depth).
  function automatic logic in_range(input logic [IdxW-1:0] idx,
                                    input logic [LenW-1:0] len);
    logic [31:0] idx_w;
    idx_w = 32'(idx);
    return (idx_w < 32'(len)) && (idx_w < VECTOR_DEPTH);
  endfunction

  function automatic logic [AW-1:0] to_addr(input logic [IdxW-1:0] idx);
    logic [31:0] idx_w;
    idx_w = 32'(idx);
    return idx_w[AW-1:0];
  endfunction

  state_e state_q, state_d;
  logic [AW-1:0] clr_cnt_q, clr_cnt_d;

  logic accept;
  logic elem_ok, row_ok, col_ok;
  logic [IdxW-1:0] src_idx, dst_idx;

  assign accept  = start && !busy;
  assign elem_ok = in_range(element_index_i, length_q);
  assign row_ok  = in_range(entry_row_i, length_q);
  assign col_ok  = in_range(entry_column_i, length_q);
  assign src_idx = transpose_q ? entry_row_i : entry_column_i;
  assign dst_idx = transpose_q ? entry_column_i : entry_row_i;

  // Request held across the sequence.
  logic [AW-1:0]         dst_addr_q;
  logic signed [ValW-1:0] entry_q;
  logic [IdxW-1:0]       rd_index_q;
  logic                  rd_err_q;

  always_ff @(posedge clk_i) begin
    if (accept) begin
      entry_q    <= entry_value_i;
      rd_index_q <= element_index_i;
      rd_err_q   <= !elem_ok;
      if (opcode_e'(opcode_i) == OP_READ) begin
        dst_addr_q <= to_addr(element_index_i);
      end else begin
        dst_addr_q <= to_addr(dst_idx);
      end
    end
  end

  // Memory port controls.
  logic                   vec_we, vec_re;
  logic                   res_we, res_re;
  logic [AW-1:0]          res_waddr, res_raddr;
  logic signed [ValW-1:0] res_wdata;
  logic signed [ValW-1:0] vec_rd_q, res_rd_q;
  logic signed [ValW-1:0] mac_sum;

  // Sequencer: next state and memory controls.
  always_comb begin
    state_d   = state_q;
    clr_cnt_d = clr_cnt_q;
    vec_we    = 1'b0;
    vec_re    = 1'b0;
    res_re    = 1'b0;
    res_raddr = to_addr(dst_idx);
    res_we    = 1'b0;
    res_waddr = dst_addr_q;
    res_wdata = mac_sum;
    case (state_q)
      ST_CLEAR: begin
        res_we    = 1'b1;
        res_waddr = clr_cnt_q;
        res_wdata = '0;
        clr_cnt_d = clr_cnt_q + AW'(1);
        if (clr_cnt_q == LastAddr) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (start) begin
          case (opcode_e'(opcode_i))
            OP_LOAD: begin
              vec_we = elem_ok;
            end
            OP_APPLY: begin
              if (row_ok && col_ok) begin
                vec_re  = 1'b1;
                res_re  = 1'b1;
                state_d = ST_MUL;
              end
            end
            OP_READ: begin
              res_re    = elem_ok;
              res_raddr = to_addr(element_index_i);
              state_d   = ST_READ;
            end
            default: ;
          endcase
        end
      end
      ST_MUL: begin
        state_d = ST_ACC;
      end
      ST_ACC: begin
        res_we  = 1'b1;
        state_d = ST_IDLE;
      end
      ST_READ: begin
        res_we    = !rd_err_q;
        res_wdata = '0;
        state_d   = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_CLEAR;
      clr_cnt_q <= '0;
    end else begin
      state_q   <= state_d;
      clr_cnt_q <= clr_cnt_d;
    end
  end

  assign busy = (state_q != ST_IDLE);

  // Vector store: written by loads, read by apply requests.
  logic signed [ValW-1:0] vec_mem [VECTOR_DEPTH];

  always_ff @(posedge clk_i) begin
    if (vec_we) begin
      vec_mem[to_addr(element_index_i)] <= element_value_i;
    end
    if (vec_re) begin
      vec_rd_q <= vec_mem[to_addr(src_idx)];
    end
  end

  // Result store: one read and one write port.
  logic signed [ValW-1:0] res_mem [VECTOR_DEPTH];

  always_ff @(posedge clk_i) begin
    if (res_we) begin
      res_mem[res_waddr] <= res_wdata;
    end
    if (res_re) begin
      res_rd_q <= res_mem[res_raddr];
    end
  end

  // Multiply and accumulate.
  smvm_mac u_mac (
    .clk_i          (clk_i),
    .mul_en_i       (state_q == ST_MUL),
    .entry_value_i  (entry_q),
    .vector_value_i (vec_rd_q),
    .accum_i        (res_rd_q),
    .sum_o          (mac_sum)
  );

  // Result outputs.
  assign result_valid_o = (state_q == ST_READ);
  assign result_index_o = rd_index_q;
  assign index_error_o  = rd_err_q;
  assign result_value_o = rd_err_q ? '0 : res_rd_q;

  // A read request produces its result on the very next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (opcode_e'(opcode_i) == OP_READ)) |=> result_valid_o)
    else $error("read request did not produce a result");

  // Each result lasts exactly one cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |=> !result_valid_o)
    else $error("result strobe held for more than one cycle");

  // An out-of-range read returns zero.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && index_error_o) |-> (result_value_o == '0))
    else $error("out-of-range read returned a nonzero value");

  // Write-back always follows the multiply cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_ACC) |-> ($past(state_q) == ST_MUL))
    else $error("accumulate without a preceding multiply");

  // No request is taken while the clearing pass runs.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CLEAR) |-> !accept)
    else $error("request accepted during clearing pass");

endmodule

FILE: test/sparse_matrix_vector_multiply_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sparse_matrix_vector_multiply_checker: result prediction and comparison
// Watches the request, configuration and result channels of the sparse
// matrix times vector block. It keeps its own copy of both stores and both
// registers, predicts every read result and compares each result strobe
// with the oldest prediction, field by field.
// ----------------------------------------------------------------------------
module sparse_matrix_vector_multiply_checker
  import smvm_pkg::*;
#(
  parameter int unsigned VECTOR_DEPTH = VectorDepthDefault
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  input  logic                   busy_i,
  input  logic [OpW-1:0]         opcode_i,
  input  logic [IdxW-1:0]        element_index_i,
  input  logic signed [ValW-1:0] element_value_i,
  input  logic [IdxW-1:0]        entry_row_i,
  input  logic [IdxW-1:0]        entry_column_i,
  input  logic signed [ValW-1:0] entry_value_i,
  input  logic                   cfg_we_i,
  input  logic                   cfg_index_i,
  input  logic [CfgW-1:0]        cfg_wdata_i,
  input  logic                   result_valid_i,
  input  logic [IdxW-1:0]        result_index_i,
  input  logic signed [ValW-1:0] result_value_i,
  input  logic                   index_error_i,
  output int unsigned            fail_count_o,
  output int unsigned            pending_o
);

  localparam longint SatMax = 64'sd2147483647;
  localparam longint SatMin = -64'sd2147483648;

  typedef struct packed {
    logic [IdxW-1:0]        index;
    logic signed [ValW-1:0] value;
    logic                   error;
  } read_result_t;

  logic signed [ValW-1:0] vector_copy [VECTOR_DEPTH];
  logic signed [ValW-1:0] result_copy [VECTOR_DEPTH];
  logic                   transpose_q;
  logic [LenW-1:0]        length_q;
  read_result_t           expected_reads [$];
  int unsigned            failures;

  // Q16.16 multiply, truncated toward minus infinity, then a saturating add.
  function automatic logic signed [ValW-1:0] accumulate_product(
      input logic signed [ValW-1:0] acc,
      input logic signed [ValW-1:0] coeff,
      input logic signed [ValW-1:0] element);
    longint product;
    longint total;
    product = longint'(coeff) * longint'(element);
    total = longint'(acc) + (product >>> 16);
    if (total > SatMax) return ValW'(SatMax);
    if (total < SatMin) return ValW'(SatMin);
    return ValW'(total);
  endfunction

  task automatic report_mismatch(input string msg);
    $display("%0t mismatch: %s", $time, msg);
    failures++;
  endtask

  // Predict on every accepted request, track register writes, check results.
  always @(posedge clk_i or negedge rst_ni) begin : predict_and_check
    int unsigned  active_len;
    int unsigned  dst;
    int unsigned  src;
    read_result_t want;
    if (!rst_ni) begin
      foreach (result_copy[i]) result_copy[i] = '0;
      transpose_q = 1'b0;
      length_q = LengthReset;
      expected_reads.delete();
      failures = 0;
      fail_count_o <= 0;
      pending_o <= 0;
    end else begin
      active_len = (length_q < VECTOR_DEPTH) ? length_q : VECTOR_DEPTH;

      if (start_i && !busy_i) begin
        case (opcode_i)
          OP_LOAD: begin
            if (element_index_i < active_len) vector_copy[element_index_i] = element_value_i;
          end
          OP_APPLY: begin
            // Entries with either index past the length are dropped.
            if (entry_row_i < active_len && entry_column_i < active_len) begin
              dst = transpose_q ? entry_column_i : entry_row_i;
              src = transpose_q ? entry_row_i : entry_column_i;
              result_copy[dst] = accumulate_product(result_copy[dst], entry_value_i,
                                                    vector_copy[src]);
            end
          end
          OP_READ: begin
            want.index = element_index_i;
            if (element_index_i < active_len) begin
              want.value = result_copy[element_index_i];
              want.error = 1'b0;
              result_copy[element_index_i] = '0;
            end else begin
              want.value = '0;
              want.error = 1'b1;
            end
            expected_reads.push_back(want);
          end
          default: ;
        endcase
      end

      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_TRANSPOSE: transpose_q = cfg_wdata_i[0];
          CFG_LENGTH:    length_q = cfg_wdata_i[LenW-1:0];
          default: ;
        endcase
      end

      if (result_valid_i) begin
        if (expected_reads.size() == 0) begin
          report_mismatch($sformatf("result with no request waiting, index %0d",
                                    result_index_i));
        end else begin
          want = expected_reads.pop_front();
          if (result_index_i !== want.index)
            report_mismatch($sformatf("result_index %0d, expected %0d",
                                      result_index_i, want.index));
          if (result_value_i !== want.value)
            report_mismatch($sformatf("index %0d: result_value %h, expected %h",
                                      want.index, result_value_i, want.value));
          if (index_error_i !== want.error)
            report_mismatch($sformatf("index %0d: index_error %b, expected %b",
                                      want.index, index_error_i, want.error));
        end
      end

      fail_count_o <= failures;
      pending_o <= expected_reads.size();
    end
  end

endmodule

FILE: test/sparse_matrix_vector_multiply_top_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sparse_matrix_vector_multiply_top_test: testbench for the sparse matrix block
// Drives a short directed sequence over saturation, rounding, dropped indices
// and zero length, then random phases of loads, entries and reads under
// varied modes and lengths with random idle bursts. A separate checker
// predicts and compares every result; this module gives the verdict.
// ----------------------------------------------------------------------------
module sparse_matrix_vector_multiply_top_test;
  import smvm_pkg::*;

  localparam int unsigned      Depth        = VectorDepthDefault;
  localparam logic [OpW-1:0]   OpUnused     = 2'd3;
  localparam int unsigned      CycleLimit   = 200000;
  localparam int unsigned      RandomPhases = 8;
  localparam int unsigned      PhaseItems   = 215;
  localparam int unsigned      ApplyLatency = 4;
  localparam int unsigned      DrainLimit   = 1000;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   start = 1'b0;
  logic                   busy;
  logic [OpW-1:0]         opcode = OP_LOAD;
  logic [IdxW-1:0]        element_index = '0;
  logic signed [ValW-1:0] element_value = '0;
  logic [IdxW-1:0]        entry_row = '0;
  logic [IdxW-1:0]        entry_column = '0;
  logic signed [ValW-1:0] entry_value = '0;
  logic                   cfg_we = 1'b0;
  cfg_index_e             cfg_index = CFG_TRANSPOSE;
  logic [CfgW-1:0]        cfg_wdata = '0;
  logic                   result_valid;
  logic [IdxW-1:0]        result_index;
  logic signed [ValW-1:0] result_value;
  logic                   index_error;
  int unsigned            fail_count;
  int unsigned            pending_reads;

  int unsigned cycle_count = 0;
  int unsigned cur_length = Depth;
  bit          cur_transpose = 1'b0;
  int unsigned idle_pct = 0;
  bit          vec_written [Depth];

  sparse_matrix_vector_multiply_top dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start           (start),
    .busy            (busy),
    .opcode_i        (opcode),
    .element_index_i (element_index),
    .element_value_i (element_value),
    .entry_row_i     (entry_row),
    .entry_column_i  (entry_column),
    .entry_value_i   (entry_value),
    .cfg_we_i        (cfg_we),
    .cfg_index_i     (cfg_index),
    .cfg_wdata_i     (cfg_wdata),
    .result_valid_o  (result_valid),
    .result_index_o  (result_index),
    .result_value_o  (result_value),
    .index_error_o   (index_error)
  );

  sparse_matrix_vector_multiply_checker result_check (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start_i         (start),
    .busy_i          (busy),
    .opcode_i        (opcode),
    .element_index_i (element_index),
    .element_value_i (element_value),
    .entry_row_i     (entry_row),
    .entry_column_i  (entry_column),
    .entry_value_i   (entry_value),
    .cfg_we_i        (cfg_we),
    .cfg_index_i     (cfg_index),
    .cfg_wdata_i     (cfg_wdata),
    .result_valid_i  (result_valid),
    .result_index_i  (result_index),
    .result_value_i  (result_value),
    .index_error_i   (index_error),
    .fail_count_o    (fail_count),
    .pending_o       (pending_reads)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Hard stop in case the block hangs.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Drive one request and hold it until the block takes it, then maybe idle.
  task automatic send_request(input logic [OpW-1:0] op, input int unsigned idx,
                              input logic signed [ValW-1:0] ev,
                              input int unsigned row, input int unsigned col,
                              input logic signed [ValW-1:0] mv);
    start <= 1'b1;
    opcode <= op;
    element_index <= IdxW'(idx);
    element_value <= ev;
    entry_row <= IdxW'(row);
    entry_column <= IdxW'(col);
    entry_value <= mv;
    if (op == OP_LOAD && idx < cur_length) vec_written[idx] = 1'b1;
    do @(posedge clk_i); while (busy);
    if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk_i);
    end
  endtask

  // Let every outstanding read return and any entry in flight finish.
  task automatic settle();
    start <= 1'b0;
    @(posedge clk_i);
    while (pending_reads != 0) @(posedge clk_i);
    repeat (ApplyLatency) @(posedge clk_i);
  endtask

  // Write both registers on back-to-back cycles.
  task automatic configure(input bit transpose, input int unsigned length);
    cfg_we <= 1'b1;
    cfg_index <= CFG_TRANSPOSE;
    cfg_wdata <= CfgW'(transpose);
    @(posedge clk_i);
    cfg_index <= CFG_LENGTH;
    cfg_wdata <= CfgW'(length);
    @(posedge clk_i);
    cfg_we <= 1'b0;
    cur_transpose = transpose;
    cur_length = (length < Depth) ? length : Depth;
  endtask

  // Half small Q16.16 values so sums stay in range, the rest random or extremes.
  function automatic logic signed [ValW-1:0] pick_value();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 50) return ValW'($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000;
    if (r < 80) return $urandom();
    case ($urandom_range(4))
      0:       return 32'sh7FFF_FFFF;
      1:       return 32'sh8000_0000;
      2:       return '0;
      3:       return 32'sh0000_0001;
      default: return 32'shFFFF_FFFF;
    endcase
  endfunction

  // A vector index below the length that has been loaded, or -1 if none.
  function automatic int written_below(input int unsigned len);
    int unsigned hits [$];
    for (int unsigned i = 0; i < len; i++) if (vec_written[i]) hits.push_back(i);
    if (hits.size() == 0) return -1;
    return hits[$urandom_range(hits.size() - 1)];
  endfunction

  // One random request; applies only read loaded elements unless dropped.
  task automatic random_request();
    int unsigned      r;
    int unsigned      len;
    int unsigned      near;
    int unsigned      eidx;
    int unsigned      row;
    int unsigned      col;
    int unsigned      dst;
    int               src;
    logic [OpW-1:0]   op;
    logic signed [ValW-1:0] ev;
    logic signed [ValW-1:0] mv;
    len = cur_length;
    near = (len < 16) ? len : 16;
    eidx = $urandom_range(Depth - 1);
    row = $urandom_range(Depth - 1);
    col = $urandom_range(Depth - 1);
    ev = pick_value();
    mv = pick_value();
    r = $urandom_range(99);
    if (r < 4) begin
      op = OpUnused;
    end else if (r < 28) begin
      op = OP_LOAD;
      if ($urandom_range(9) != 0) eidx = $urandom_range(len - 1);
    end else if (r < 78) begin
      op = OP_APPLY;
      src = written_below(len);
      if (len < Depth && (src < 0 || $urandom_range(9) == 0)) begin
        // Push one of the indices past the length so the entry is dropped.
        if ($urandom_range(1)) row = $urandom_range(len, Depth - 1);
        else col = $urandom_range(len, Depth - 1);
      end else if (src < 0) begin
        op = OP_LOAD;
        eidx = $urandom_range(len - 1);
      end else begin
        dst = $urandom_range(1) ? $urandom_range(near - 1) : $urandom_range(len - 1);
        if (cur_transpose) begin
          row = src;
          col = dst;
        end else begin
          row = dst;
          col = src;
        end
      end
    end else begin
      op = OP_READ;
      r = $urandom_range(9);
      if (r >= 1 && r <= 5) eidx = $urandom_range(near - 1);
      else if (r > 5) eidx = $urandom_range(len - 1);
    end
    send_request(op, eidx, ev, row, col, mv);
  endtask

  initial begin
    int unsigned p;
    int unsigned len;
    int unsigned drain;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    // Registers are taken during the clearing pass after reset.
    configure(1'b0, Depth);

    // Full length, plain mode: saturation both ways and floor rounding.
    send_request(OP_LOAD, 0, 32'sh7FFF_FFFF, 0, 0, '0);
    send_request(OP_LOAD, Depth - 1, 32'sh8000_0000, 0, 0, '0);
    send_request(OP_LOAD, 6, 32'shFFFF_FFFF, 0, 0, '0);
    send_request(OP_APPLY, 0, '0, 0, 0, 32'sh7FFF_FFFF);
    send_request(OP_APPLY, 0, '0, Depth - 1, Depth - 1, 32'sh7FFF_FFFF);
    send_request(OP_APPLY, 0, '0, 3, 6, 32'sh0000_0001);
    send_request(OpUnused, 3, 32'sh1234_5678, 3, 6, 32'sh7FFF_FFFF);
    send_request(OP_READ, 0, '0, 0, 0, '0);
    send_request(OP_READ, Depth - 1, '0, 0, 0, '0);
    send_request(OP_READ, 3, '0, 0, 0, '0);
    send_request(OP_READ, 0, '0, 0, 0, '0);

    // Short length, transpose mode: dropped loads, entries and reads.
    settle();
    configure(1'b1, 8);
    send_request(OP_LOAD, 9, 32'sh0005_0000, 0, 0, '0);
    send_request(OP_LOAD, 7, 32'sh0002_0000, 0, 0, '0);
    send_request(OP_APPLY, 0, '0, 7, 2, 32'sh0001_8000);
    send_request(OP_APPLY, 0, '0, 8, 2, 32'sh0001_0000);
    send_request(OP_READ, 2, '0, 0, 0, '0);
    send_request(OP_READ, 8, '0, 0, 0, '0);

    // Zero length: everything is out of range.
    settle();
    configure(1'b1, 0);
    send_request(OP_READ, 0, '0, 0, 0, '0);
    send_request(OP_LOAD, 0, 32'sh0001_0000, 0, 0, '0);
    send_request(OP_APPLY, 0, '0, 0, 0, 32'sh0001_0000);

    // Length one, plain mode.
    settle();
    configure(1'b0, 1);
    send_request(OP_APPLY, 0, '0, 0, 0, 32'sh0001_0000);
    send_request(OP_READ, 0, '0, 0, 0, '0);
    send_request(OP_READ, 1, '0, 0, 0, '0);

    // Random phases over modes and lengths; the last one runs without gaps.
    for (p = 0; p < RandomPhases; p++) begin
      if (p == 0 || p == RandomPhases - 1) len = Depth;
      else if (p == 1) len = 1;
      else if (p == 2) len = 2;
      else if (p == 3) len = Depth - 1;
      else if ($urandom_range(1)) len = $urandom_range(3, 64);
      else len = $urandom_range(1, Depth);
      settle();
      configure(p[0], len);
      if (p == RandomPhases - 1) begin
        idle_pct = 0;
      end else begin
        case ($urandom_range(2))
          0:       idle_pct = 0;
          1:       idle_pct = 15;
          default: idle_pct = 40;
        endcase
      end
      repeat (PhaseItems) random_request();
    end

    start <= 1'b0;
    @(posedge clk_i);
    drain = 0;
    while (pending_reads != 0 && drain < DrainLimit) begin
      @(posedge clk_i);
      drain++;
    end
    repeat (ApplyLatency + 4) @(posedge clk_i);
    if (fail_count == 0 && pending_reads == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
